// File: sv/rta_pkg.sv
// shared constants, register indexes and helpers for the raster to tile address scatter
package rta_pkg;

    localparam int ADDR_BITS_DEF = 24;
    localparam int ADDR_OUT_W    = 24;
    localparam int PIX_W         = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;

    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MASK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_ACROSS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SHIFT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MASK      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd7;

    localparam logic [7:0]  RST_VALUE_MASK    = 8'd255;
    localparam logic [8:0]  RST_BLOCK_WIDTH   = 9'd8;
    localparam logic [8:0]  RST_BLOCK_HEIGHT  = 9'd8;
    localparam logic [9:0]  RST_BLOCKS_ACROSS = 10'd80;
    localparam logic [3:0]  RST_ROW_SHIFT     = 4'd3;
    localparam logic [7:0]  RST_ROW_MASK      = 8'd7;
    localparam logic [12:0] RST_FRAME_WIDTH   = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT  = 13'd480;

    // zero acts as one, large values saturate
    function automatic logic [12:0] f_clamp(input logic [12:0] v, input logic [12:0] vmax);
        logic [12:0] r;
        begin
            if (v == 13'd0) begin
                r = 13'd1;
            end else if (v > vmax) begin
                r = vmax;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

// File: sv/rta_if.sv
// request channel interfaces: pixel input, address result and register write
interface rta_pix_if;
    import rta_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface rta_res_if;
    import rta_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ADDR_OUT_W-1:0] write_address;
    logic [PIX_W-1:0]      write_value;
    logic                  frame_end;
    modport source (output valid, output write_address, output write_value,
                    output frame_end, input ready);
    modport sink   (input valid, input write_address, input write_value,
                    input frame_end, output ready);
endinterface

interface rta_cfg_if;
    import rta_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/raster_to_tile_address_scatter.sv
// top level: raster pixel stream to tiled buffer write address and masked value
//
// i_pix carries one 8-bit pixel per request in raster order. o_res returns one
// request per pixel with its tiled buffer address, the pixel ANDed with the
// value mask, and frame_end set on the last pixel of the frame. i_cfg writes
// the eight size and mask registers by index and is always ready; write only
// while no pixel is in flight.
// Running row, column and block counters advance when a pixel is accepted.
// The position is then registered with the masked pixel, and the address goes
// through the register stages for the products of the sizes, block index times
// block size and the final add, which drives o_res. Throughput is one pixel per
// cycle while o_res.ready stays high, set by the counter update; each stage
// holds only when its successor is full and stalled, so bubbles are absorbed
// and a stalled receiver backs up the pipeline stage by stage until i_pix.ready drops.
// Reset clears the counters and valid flags and loads the default registers
// (8x8 blocks, 80 blocks across, 640x480 frame).
module raster_to_tile_address_scatter #(
    parameter int ADDR_BITS = rta_pkg::ADDR_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rta_pix_if.sink   i_pix,
    rta_cfg_if.sink   i_cfg,
    rta_res_if.source o_res
);
    import rta_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int XW = (AW > ADDR_OUT_W) ? AW : ADDR_OUT_W;

    // configuration
    logic [7:0]  r_value_mask;
    logic [8:0]  r_block_width;
    logic [8:0]  r_block_height;
    logic [9:0]  r_blocks_across;
    logic [3:0]  r_row_shift;
    logic [7:0]  r_row_mask;
    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;

    // running position
    logic [11:0] r_row, n_row;
    logic [11:0] r_col, n_col;
    logic [8:0]  r_bcol, n_bcol;
    logic [7:0]  r_off, n_off;

    // pipeline
    logic        r_v1, r_v2, r_v3, r_vo;
    logic [11:0] r_s1_row;
    logic [8:0]  r_s1_bcol;
    logic [7:0]  r_s1_off;
    logic [7:0]  r_s1_val;
    logic        r_s1_end;
    logic [21:0] r_s2_a;
    logic [8:0]  r_s2_bcol;
    logic [16:0] r_s2_bs;
    logic [17:0] r_s2_lo;
    logic [7:0]  r_s2_val;
    logic        r_s2_end;
    logic [AW-1:0] r_s3_t;
    logic [17:0] r_s3_lo;
    logic [7:0]  r_s3_val;
    logic        r_s3_end;
    logic [AW-1:0] r_addr;
    logic [7:0]  r_val;
    logic        r_end;

    logic [8:0]  w_bw, w_bh;
    logic [9:0]  w_ba;
    logic [12:0] w_fw, w_fh;
    logic        w_block_done, w_row_done, w_frame_done;
    logic        w_en1, w_en2, w_en3, w_eno, w_fire;
    logic [11:0] w_rowhi;
    logic [21:0] w_a;
    logic [16:0] w_bs, w_rlo;
    logic [22:0] w_blk;
    logic [AW-1:0] w_t;
    logic [XW-1:0] w_addr_ext;

    assign w_bw = 9'(f_clamp(13'(r_block_width), 13'd256));
    assign w_bh = 9'(f_clamp(13'(r_block_height), 13'd256));
    assign w_ba = 10'(f_clamp(13'(r_blocks_across), 13'd512));
    assign w_fw = f_clamp(r_frame_width, 13'd4096);
    assign w_fh = f_clamp(r_frame_height, 13'd4096);

    assign w_eno = !r_vo || o_res.ready;
    assign w_en3 = !r_v3 || w_eno;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_pix.ready = w_en1;
    assign w_fire = i_pix.valid && w_en1;
    assign i_cfg.ready = 1'b1;

    // position counters
    always_comb begin
        w_block_done = (9'(r_off) + 9'd1) >= w_bw;
        w_row_done   = ((13'(r_col) + 13'd1) >= w_fw)
                    || (w_block_done && ((10'(r_bcol) + 10'd1) >= w_ba));
        w_frame_done = w_row_done && ((13'(r_row) + 13'd1) >= w_fh);
        n_row  = r_row;
        n_col  = r_col;
        n_bcol = r_bcol;
        n_off  = r_off;
        if (w_row_done) begin
            n_col  = 12'd0;
            n_bcol = 9'd0;
            n_off  = 8'd0;
            n_row  = w_frame_done ? 12'd0 : r_row + 12'd1;
        end else begin
            n_col = r_col + 12'd1;
            if (w_block_done) begin
                n_off  = 8'd0;
                n_bcol = r_bcol + 9'd1;
            end else begin
                n_off = r_off + 8'd1;
            end
        end
    end

    // stage arithmetic
    assign w_rowhi = r_s1_row >> r_row_shift;
    assign w_a     = 22'(w_rowhi) * 22'(w_ba);
    assign w_bs    = 17'(w_bw) * 17'(w_bh);
    assign w_rlo   = 17'(r_s1_row[7:0] & r_row_mask) * 17'(w_bw);
    assign w_blk   = 23'(r_s2_a) + 23'(r_s2_bcol);
    assign w_t     = AW'(w_blk) * AW'(r_s2_bs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_mask    <= RST_VALUE_MASK;
            r_block_width   <= RST_BLOCK_WIDTH;
            r_block_height  <= RST_BLOCK_HEIGHT;
            r_blocks_across <= RST_BLOCKS_ACROSS;
            r_row_shift     <= RST_ROW_SHIFT;
            r_row_mask      <= RST_ROW_MASK;
            r_frame_width   <= RST_FRAME_WIDTH;
            r_frame_height  <= RST_FRAME_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_VALUE_MASK:    r_value_mask    <= i_cfg.data[7:0];
                REG_BLOCK_WIDTH:   r_block_width   <= i_cfg.data[8:0];
                REG_BLOCK_HEIGHT:  r_block_height  <= i_cfg.data[8:0];
                REG_BLOCKS_ACROSS: r_blocks_across <= i_cfg.data[9:0];
                REG_ROW_SHIFT:     r_row_shift     <= i_cfg.data[3:0];
                REG_ROW_MASK:      r_row_mask      <= i_cfg.data[7:0];
                REG_FRAME_WIDTH:   r_frame_width   <= i_cfg.data;
                REG_FRAME_HEIGHT:  r_frame_height  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= 12'd0;
            r_col  <= 12'd0;
            r_bcol <= 9'd0;
            r_off  <= 8'd0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vo   <= 1'b0;
        end else begin
            if (w_fire) begin
                r_row  <= n_row;
                r_col  <= n_col;
                r_bcol <= n_bcol;
                r_off  <= n_off;
            end
            if (w_en1) r_v1 <= i_pix.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_eno) r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_row  <= r_row;
            r_s1_bcol <= r_bcol;
            r_s1_off  <= r_off;
            r_s1_val  <= i_pix.pixel & r_value_mask;
            r_s1_end  <= w_frame_done;
        end
        if (w_en2) begin
            r_s2_a    <= w_a;
            r_s2_bcol <= r_s1_bcol;
            r_s2_bs   <= w_bs;
            r_s2_lo   <= 18'(w_rlo) + 18'(r_s1_off);
            r_s2_val  <= r_s1_val;
            r_s2_end  <= r_s1_end;
        end
        if (w_en3) begin
            r_s3_t   <= w_t;
            r_s3_lo  <= r_s2_lo;
            r_s3_val <= r_s2_val;
            r_s3_end <= r_s2_end;
        end
        if (w_eno) begin
            r_addr <= r_s3_t + AW'(r_s3_lo);
            r_val  <= r_s3_val;
            r_end  <= r_s3_end;
        end
    end

    assign w_addr_ext          = XW'(r_addr);
    assign o_res.valid         = r_vo;
    assign o_res.write_address = w_addr_ext[ADDR_OUT_W-1:0];
    assign o_res.write_value   = r_val;
    assign o_res.frame_end     = r_end;

endmodule
